FILE: rtl/drpb_pkg.sv
// Shared types and constants for the depth ROI point back-projector.
// Used by the front, queue, back and top-level modules; no dependencies.
package drpb_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_ROI_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_ROI_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_ROI_WIDTH       = 3'd2;
   localparam logic [2:0] REG_ROI_HEIGHT      = 3'd3;
   localparam logic [2:0] REG_PRINCIPAL_X_Q4  = 3'd4;
   localparam logic [2:0] REG_PRINCIPAL_Y_Q4  = 3'd5;
   localparam logic [2:0] REG_INV_FOCAL_X_Q24 = 3'd6;
   localparam logic [2:0] REG_INV_FOCAL_Y_Q24 = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   // Register reset values.
   localparam logic [9:0]  RST_ROI_CENTER_X    = 10'd320;
   localparam logic [9:0]  RST_ROI_CENTER_Y    = 10'd240;
   localparam logic [9:0]  RST_ROI_WIDTH       = 10'd0;
   localparam logic [9:0]  RST_ROI_HEIGHT      = 10'd0;
   localparam logic [13:0] RST_PRINCIPAL_X_Q4  = 14'd5149;
   localparam logic [13:0] RST_PRINCIPAL_Y_Q4  = 14'd3796;
   localparam logic [17:0] RST_INV_FOCAL_X_Q24 = 18'd27239;
   localparam logic [17:0] RST_INV_FOCAL_Y_Q24 = 18'd27254;

   // Accepted depth window in millimeters.
   localparam logic [15:0] DEPTH_MIN_MM = 16'd101;
   localparam logic [15:0] DEPTH_MAX_MM = 16'd4999;

   // Output saturation limits, as magnitudes.
   localparam logic [21:0] OUT_POS_MAX = 22'd524287;
   localparam logic [21:0] OUT_NEG_MAX = 22'd524288;
   localparam logic [19:0] OUT_POS_SAT = 20'h7FFFF;
   localparam logic [19:0] OUT_NEG_SAT = 20'h80000;

   typedef struct packed {
      logic [9:0]  roi_center_x;
      logic [9:0]  roi_center_y;
      logic [9:0]  roi_width;
      logic [9:0]  roi_height;
      logic [13:0] principal_x_q4;
      logic [13:0] principal_y_q4;
      logic [17:0] inv_focal_x_q24;
      logic [17:0] inv_focal_y_q24;
   } drpb_cfg_type;

   // A classified pixel waiting for back-projection.
   typedef struct packed {
      logic        neg_x;
      logic [13:0] mag_x;
      logic        neg_y;
      logic [13:0] mag_y;
      logic [12:0] z_mm;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } drpb_entry_type;

   // Box test on one axis: centre - size/2 <= p < centre + size/2, even offset.
   function automatic logic axis_in_box(input logic [9:0] p, input logic [9:0] centre,
                                        input logic [9:0] size);
      logic signed [11:0] lo;
      logic signed [11:0] hi;
      logic signed [11:0] pos;
      lo  = $signed({2'b00, centre}) - $signed({3'b000, size[9:1]});
      hi  = $signed({2'b00, centre}) + $signed({3'b000, size[9:1]});
      pos = $signed({2'b00, p});
      return (pos >= lo) && (pos < hi) && (p[0] == lo[0]);
   endfunction

   // Offset of a pixel from the principal point, in sixteenths, as sign and magnitude.
   function automatic logic [14:0] principal_offset(input logic [9:0] p,
                                                    input logic [13:0] principal);
      logic signed [14:0] d;
      logic signed [14:0] m;
      d = $signed({1'b0, p, 4'b0000}) - $signed({1'b0, principal});
      m = d[14] ? -d : d;
      return {d[14], m[13:0]};
   endfunction

endpackage

FILE: rtl/depth_roi_point_backprojector.sv
// Depth ROI point back-projector, top level: register file, front end,
// queue and back end. Uses drpb_pkg, drpb_front, drpb_queue and drpb_back.
//
// Usage: each request on the req_ channel is one depth pixel (column, row,
// raw depth in mm, color). A pixel inside the image and the configured box,
// at an even offset from the box start and with a depth of 101 to 4999 mm,
// produces one response on the rsp_ channel: X and Y in 1/16 mm (saturated to
// 20 bits signed), Z in mm and the color. Other pixels produce nothing.
// Both channels move an item at a clock edge where valid is high and stall is
// low. Configuration is written through csr_wr_en, csr_index and csr_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
// Throughput is one request per cycle while req_stall is low. A response passes
// through the classify register, the queue, and the two multiply stages ahead
// of the response register.
// While the receiver stalls, the back pipeline holds; the front keeps taking
// requests until the queue of QUEUE_DEPTH entries is full and a passing pixel
// waits in the classify register, then stalls req_.
// Reset is synchronous: it empties the pipeline and queue and loads the
// register defaults (empty box, so nothing passes until a box is written).
module depth_roi_point_backprojector
   import drpb_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [9:0]             req_pixel_col,
   input  logic [9:0]             req_pixel_row,
   input  logic [15:0]            req_depth_raw,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_red,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [19:0]     rsp_point_x_q4,
   output logic signed [19:0]     rsp_point_y_q4,
   output logic [12:0]            rsp_point_z_mm,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_red
);

   drpb_cfg_type   cfg_ff, cfg_in;
   logic           push_valid;
   drpb_entry_type push_entry;
   logic           queue_full;
   logic           pop;
   logic           pop_valid;
   drpb_entry_type pop_entry;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_ROI_CENTER_X:    cfg_in.roi_center_x    = csr_wdata[9:0];
            REG_ROI_CENTER_Y:    cfg_in.roi_center_y    = csr_wdata[9:0];
            REG_ROI_WIDTH:       cfg_in.roi_width       = csr_wdata[9:0];
            REG_ROI_HEIGHT:      cfg_in.roi_height      = csr_wdata[9:0];
            REG_PRINCIPAL_X_Q4:  cfg_in.principal_x_q4  = csr_wdata[13:0];
            REG_PRINCIPAL_Y_Q4:  cfg_in.principal_y_q4  = csr_wdata[13:0];
            REG_INV_FOCAL_X_Q24: cfg_in.inv_focal_x_q24 = csr_wdata[17:0];
            REG_INV_FOCAL_Y_Q24: cfg_in.inv_focal_y_q24 = csr_wdata[17:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roi_center_x    <= RST_ROI_CENTER_X;
         cfg_ff.roi_center_y    <= RST_ROI_CENTER_Y;
         cfg_ff.roi_width       <= RST_ROI_WIDTH;
         cfg_ff.roi_height      <= RST_ROI_HEIGHT;
         cfg_ff.principal_x_q4  <= RST_PRINCIPAL_X_Q4;
         cfg_ff.principal_y_q4  <= RST_PRINCIPAL_Y_Q4;
         cfg_ff.inv_focal_x_q24 <= RST_INV_FOCAL_X_Q24;
         cfg_ff.inv_focal_y_q24 <= RST_INV_FOCAL_Y_Q24;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: request acceptance and classification.
   drpb_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .req_depth_raw (req_depth_raw),
      .req_blue      (req_blue),
      .req_green     (req_green),
      .req_red       (req_red),
      .push_valid    (push_valid),
      .push_entry    (push_entry),
      .queue_full    (queue_full)
   );

   // Decoupling queue.
   drpb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Back end: projection arithmetic and response register.
   drpb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pop_valid      (pop_valid),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_x_q4 (rsp_point_x_q4),
      .rsp_point_y_q4 (rsp_point_y_q4),
      .rsp_point_z_mm (rsp_point_z_mm),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red)
   );

endmodule

FILE: rtl/drpb_front.sv
// Front end: accepts pixel requests, runs the image, box and depth tests,
// and forwards passing pixels with their principal offsets. Uses drpb_pkg.
module drpb_front
   import drpb_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480
) (
   input  logic           clock,
   input  logic           reset,
   input  drpb_cfg_type   cfg,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [9:0]     req_pixel_col,
   input  logic [9:0]     req_pixel_row,
   input  logic [15:0]    req_depth_raw,
   input  logic [7:0]     req_blue,
   input  logic [7:0]     req_green,
   input  logic [7:0]     req_red,
   output logic           push_valid,
   output drpb_entry_type push_entry,
   input  logic           queue_full
);

   logic           valid_ff, valid_in;
   drpb_entry_type entry_ff, entry_in;
   logic           pass;
   logic           load;
   logic [14:0]    off_x, off_y;

   // Classification of the incoming request.
   always_comb begin
      pass = ({1'b0, req_pixel_col} < 11'(IMAGE_WIDTH)) &&
             ({1'b0, req_pixel_row} < 11'(IMAGE_HEIGHT)) &&
             axis_in_box(req_pixel_col, cfg.roi_center_x, cfg.roi_width) &&
             axis_in_box(req_pixel_row, cfg.roi_center_y, cfg.roi_height) &&
             (req_depth_raw >= DEPTH_MIN_MM) && (req_depth_raw <= DEPTH_MAX_MM);
      off_x = principal_offset(req_pixel_col, cfg.principal_x_q4);
      off_y = principal_offset(req_pixel_row, cfg.principal_y_q4);
      entry_in.neg_x = off_x[14];
      entry_in.mag_x = off_x[13:0];
      entry_in.neg_y = off_y[14];
      entry_in.mag_y = off_y[13:0];
      entry_in.z_mm  = req_depth_raw[12:0];
      entry_in.blue  = req_blue;
      entry_in.green = req_green;
      entry_in.red   = req_red;
   end

   // The stage moves whenever it is empty or its entry enters the queue.
   assign load      = !valid_ff || !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign valid_in  = load ? (req_valid && pass) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

FILE: rtl/drpb_queue.sv
// Short FIFO between the front and back ends so each side stalls on its own.
// Uses drpb_pkg for the entry type.
module drpb_queue
   import drpb_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  drpb_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           pop_valid,
   output drpb_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   drpb_entry_type       slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_entry = slots_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/drpb_back.sv
// Back end: three-stage back-projection pipeline (offset times depth, times
// reciprocal focal length, round and saturate) ending in the response register.
// Uses drpb_pkg.
module drpb_back
   import drpb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  drpb_cfg_type       cfg,
   input  logic               pop_valid,
   input  drpb_entry_type     pop_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [19:0] rsp_point_x_q4,
   output logic signed [19:0] rsp_point_y_q4,
   output logic [12:0]        rsp_point_z_mm,
   output logic [7:0]         rsp_out_blue,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_red
);

   localparam logic [45:0] ROUND_HALF = 46'd1 << 23;

   typedef struct packed {
      logic        neg_x;
      logic [26:0] prod_x;
      logic        neg_y;
      logic [26:0] prod_y;
      logic [12:0] z_mm;
      logic [23:0] color;
   } drpb_s1_type;

   typedef struct packed {
      logic        neg_x;
      logic [44:0] prod_x;
      logic        neg_y;
      logic [44:0] prod_y;
      logic [12:0] z_mm;
      logic [23:0] color;
   } drpb_s2_type;

   logic        adv;
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        out_valid_ff, out_valid_in;
   drpb_s1_type s1_ff, s1_in;
   drpb_s2_type s2_ff, s2_in;
   logic [19:0] x_ff, x_in;
   logic [19:0] y_ff, y_in;
   logic [12:0] z_ff;
   logic [23:0] color_ff;
   logic [45:0] sum_x, sum_y;
   logic [21:0] q_x, q_y;

   // The whole pipeline moves together unless the response is held.
   assign adv          = !out_valid_ff || !rsp_stall;
   assign pop          = adv;
   assign s1_valid_in  = pop_valid;
   assign s2_valid_in  = s1_valid_ff;
   assign out_valid_in = s2_valid_ff;

   // Stage one: offset magnitude times depth.
   always_comb begin
      s1_in.neg_x  = pop_entry.neg_x;
      s1_in.prod_x = {13'd0, pop_entry.mag_x} * {14'd0, pop_entry.z_mm};
      s1_in.neg_y  = pop_entry.neg_y;
      s1_in.prod_y = {13'd0, pop_entry.mag_y} * {14'd0, pop_entry.z_mm};
      s1_in.z_mm   = pop_entry.z_mm;
      s1_in.color  = {pop_entry.blue, pop_entry.green, pop_entry.red};
   end

   // Stage two: times the Q24 reciprocal focal length.
   always_comb begin
      s2_in.neg_x  = s1_ff.neg_x;
      s2_in.prod_x = {18'd0, s1_ff.prod_x} * {27'd0, cfg.inv_focal_x_q24};
      s2_in.neg_y  = s1_ff.neg_y;
      s2_in.prod_y = {18'd0, s1_ff.prod_y} * {27'd0, cfg.inv_focal_y_q24};
      s2_in.z_mm   = s1_ff.z_mm;
      s2_in.color  = s1_ff.color;
   end

   // Stage three: round half away from zero, restore sign, saturate to 20 bits.
   always_comb begin
      sum_x = {1'b0, s2_ff.prod_x} + ROUND_HALF;
      sum_y = {1'b0, s2_ff.prod_y} + ROUND_HALF;
      q_x   = sum_x[45:24];
      q_y   = sum_y[45:24];
      if (s2_ff.neg_x) begin
         x_in = (q_x > OUT_NEG_MAX) ? OUT_NEG_SAT : 20'(22'd0 - q_x);
      end else begin
         x_in = (q_x > OUT_POS_MAX) ? OUT_POS_SAT : q_x[19:0];
      end
      if (s2_ff.neg_y) begin
         y_in = (q_y > OUT_NEG_MAX) ? OUT_NEG_SAT : 20'(22'd0 - q_y);
      end else begin
         y_in = (q_y > OUT_POS_MAX) ? OUT_POS_SAT : q_y[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= s2_ff.z_mm;
         color_ff <= s2_ff.color;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x_q4 = $signed(x_ff);
   assign rsp_point_y_q4 = $signed(y_ff);
   assign rsp_point_z_mm = z_ff;
   assign rsp_out_blue   = color_ff[23:16];
   assign rsp_out_green  = color_ff[15:8];
   assign rsp_out_red    = color_ff[7:0];

endmodule

FILE: tb/sv/depth_roi_point_backprojector_checker.sv
// Checker for the depth ROI point back-projector: tracks register writes, predicts
// the point for every accepted request and compares each response field by field.
// Depends on drpb_pkg for the configuration record, the register indexes and resets.
module depth_roi_point_backprojector_checker
   import drpb_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [9:0]             req_pixel_col,
   input  logic [9:0]             req_pixel_row,
   input  logic [15:0]            req_depth_raw,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_red,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic signed [19:0]     rsp_point_x_q4,
   input  logic signed [19:0]     rsp_point_y_q4,
   input  logic [12:0]            rsp_point_z_mm,
   input  logic [7:0]             rsp_out_blue,
   input  logic [7:0]             rsp_out_green,
   input  logic [7:0]             rsp_out_red,
   output int                     fail_count,
   output int                     points_pending
);

   localparam int     NEAREST_MM = 101;
   localparam int     FARTHEST_MM = 4999;
   localparam longint COORD_MAX = 524287;
   localparam longint COORD_MIN = -524288;

   typedef struct packed {
      logic signed [19:0] x_q4;
      logic signed [19:0] y_q4;
      logic [12:0]        z_mm;
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
   } point_type;

   drpb_cfg_type cfg;
   point_type    expected_points[$];

   initial begin
      fail_count = 0;
      points_pending = 0;
   end

   // One axis of the box: from centre - size/2 up to but not including centre + size/2,
   // on even offsets from the start, and never beyond the image edge.
   function automatic bit axis_accepts(input int p, input int centre, input int size,
                                       input int limit);
      int half;
      int lo;
      int hi;
      half = size / 2;
      lo = centre - half;
      hi = centre + half;
      return (p < limit) && (p >= lo) && (p < hi) && (((p - lo) % 2) == 0);
   endfunction

   // Pinhole back-projection of one coordinate to 1/16 mm, rounded half away from
   // zero and clamped to the 20-bit signed range.
   function automatic logic signed [19:0] backproject_q4(input int p, input int principal,
                                                         input int z_mm, input int inv_q24);
      longint          offset;
      longint unsigned mag;
      longint unsigned scaled;
      longint          clamped;
      offset = 16 * longint'(p) - longint'(principal);
      mag = (offset < 0) ? -offset : offset;
      scaled = (mag * longint'(z_mm) * longint'(inv_q24) + (64'd1 << 23)) >> 24;
      if (offset < 0) begin
         clamped = (scaled > -COORD_MIN) ? COORD_MIN : -longint'(scaled);
      end else begin
         clamped = (scaled > COORD_MAX) ? COORD_MAX : longint'(scaled);
      end
      return clamped[19:0];
   endfunction

   // Works out whether a pixel becomes a point under the current registers, and which.
   function automatic bit predict_point(input logic [9:0] col, input logic [9:0] row,
                                        input logic [15:0] depth, input logic [7:0] blue,
                                        input logic [7:0] green, input logic [7:0] red,
                                        output point_type pt);
      pt = '0;
      if (!axis_accepts(col, cfg.roi_center_x, cfg.roi_width, IMAGE_WIDTH)) return 0;
      if (!axis_accepts(row, cfg.roi_center_y, cfg.roi_height, IMAGE_HEIGHT)) return 0;
      if (depth < NEAREST_MM || depth > FARTHEST_MM) return 0;
      pt.x_q4 = backproject_q4(col, cfg.principal_x_q4, depth, cfg.inv_focal_x_q24);
      pt.y_q4 = backproject_q4(row, cfg.principal_y_q4, depth, cfg.inv_focal_y_q24);
      pt.z_mm = depth[12:0];
      pt.blue = blue;
      pt.green = green;
      pt.red = red;
      return 1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // Register shadow, prediction on accepted requests and comparison on accepted responses.
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         cfg = '{roi_center_x: RST_ROI_CENTER_X, roi_center_y: RST_ROI_CENTER_Y,
                 roi_width: RST_ROI_WIDTH, roi_height: RST_ROI_HEIGHT,
                 principal_x_q4: RST_PRINCIPAL_X_Q4, principal_y_q4: RST_PRINCIPAL_Y_Q4,
                 inv_focal_x_q24: RST_INV_FOCAL_X_Q24, inv_focal_y_q24: RST_INV_FOCAL_Y_Q24};
         expected_points.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ROI_CENTER_X:    cfg.roi_center_x = csr_wdata[9:0];
               REG_ROI_CENTER_Y:    cfg.roi_center_y = csr_wdata[9:0];
               REG_ROI_WIDTH:       cfg.roi_width = csr_wdata[9:0];
               REG_ROI_HEIGHT:      cfg.roi_height = csr_wdata[9:0];
               REG_PRINCIPAL_X_Q4:  cfg.principal_x_q4 = csr_wdata[13:0];
               REG_PRINCIPAL_Y_Q4:  cfg.principal_y_q4 = csr_wdata[13:0];
               REG_INV_FOCAL_X_Q24: cfg.inv_focal_x_q24 = csr_wdata[17:0];
               REG_INV_FOCAL_Y_Q24: cfg.inv_focal_y_q24 = csr_wdata[17:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_point(req_pixel_col, req_pixel_row, req_depth_raw,
                              req_blue, req_green, req_red, want)) begin
               expected_points.insert(expected_points.size(), want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report_mismatch("point arrived with no request waiting for one");
            end else begin
               want = expected_points.pop_front();
               check_field("point_x_q4", rsp_point_x_q4, want.x_q4);
               check_field("point_y_q4", rsp_point_y_q4, want.y_q4);
               check_field("point_z_mm", rsp_point_z_mm, want.z_mm);
               check_field("out_blue", rsp_out_blue, want.blue);
               check_field("out_green", rsp_out_green, want.green);
               check_field("out_red", rsp_out_red, want.red);
            end
         end
      end
      points_pending <= expected_points.size();
   end

endmodule

FILE: tb/sv/depth_roi_point_backprojector_test.sv
// Top of the back-projector testbench: clock, reset, register setup, pixel requests
// and flow control, with the checker beside the block and the final verdict.
// Depends on drpb_pkg, depth_roi_point_backprojector and its checker.
module depth_roi_point_backprojector_test;
   import drpb_pkg::*;

   localparam int IMAGE_WIDTH     = 640;
   localparam int IMAGE_HEIGHT    = 480;
   // Extra settling time once the last expected point is out.
   localparam int DRAIN_CYCLES    = 10;
   // Random gaps and stalls of this length are practically impossible in a good run.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 112;

   typedef enum {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [9:0]             req_pixel_col = '0;
   logic [9:0]             req_pixel_row = '0;
   logic [15:0]            req_depth_raw = '0;
   logic [7:0]             req_blue = '0;
   logic [7:0]             req_green = '0;
   logic [7:0]             req_red = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [19:0]     rsp_point_x_q4;
   logic signed [19:0]     rsp_point_y_q4;
   logic [12:0]            rsp_point_z_mm;
   logic [7:0]             rsp_out_blue;
   logic [7:0]             rsp_out_green;
   logic [7:0]             rsp_out_red;

   int fail_count;
   int points_pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   // Box as last written, used only to aim requests into it.
   int box_cx;
   int box_cy;
   int box_w;
   int box_h;

   depth_roi_point_backprojector #(
      .IMAGE_WIDTH (IMAGE_WIDTH),
      .IMAGE_HEIGHT(IMAGE_HEIGHT)
   ) i_dut (.*);

   depth_roi_point_backprojector_checker #(
      .IMAGE_WIDTH (IMAGE_WIDTH),
      .IMAGE_HEIGHT(IMAGE_HEIGHT)
   ) i_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls at random, independently of what the block shows.
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // End the run when nothing has moved on any port for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_STEADY:          begin idle_pct = 0;  stall_pct = 0;  end
         PACE_SENDER_GAPS:     begin idle_pct = 46; stall_pct = 0;  end
         PACE_RECEIVER_STALLS: begin idle_pct = 0;  stall_pct = 46; end
         default:              begin idle_pct = 37; stall_pct = 37; end
      endcase
   endtask

   // Called at a falling edge; the bits above the register width carry junk.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value,
                            input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      junk = junk << width;
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= junk | CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic load_config(input int cx, input int cy, input int w, input int h,
                              input int px, input int py, input int fx, input int fy);
      write_reg(REG_ROI_CENTER_X, cx, 10);
      write_reg(REG_ROI_CENTER_Y, cy, 10);
      write_reg(REG_ROI_WIDTH, w, 10);
      write_reg(REG_ROI_HEIGHT, h, 10);
      write_reg(REG_PRINCIPAL_X_Q4, px, 14);
      write_reg(REG_PRINCIPAL_Y_Q4, py, 14);
      write_reg(REG_INV_FOCAL_X_Q24, fx, 18);
      write_reg(REG_INV_FOCAL_Y_Q24, fy, 18);
      csr_wr_en <= 1'b0;
      box_cx = cx;
      box_cy = cy;
      box_w = w;
      box_h = h;
   endtask

   // Presents one pixel request, after an optional random gap, and holds it until taken.
   task automatic send_pixel(input int col, input int row, input int depth,
                             input int blue, input int green, input int red);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_col <= 10'(col);
      req_pixel_row <= 10'(row);
      req_depth_raw <= 16'(depth);
      req_blue <= 8'(blue);
      req_green <= 8'(green);
      req_red <= 8'(red);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Waits until every expected point is out, then lets dropped pixels drain.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (points_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Picks a coordinate that passes the box test on one axis, if there is one.
   function automatic bit pick_in_box(input int centre, input int size, input int limit,
                                      output int p);
      int first;
      int last;
      first = centre - size / 2;
      last = centre + size / 2 - 1;
      if (last > limit - 1) last = limit - 1;
      if (first < 0) first = first + 2 * ((1 - first) / 2);
      p = 0;
      if (first > last) return 0;
      p = first + 2 * $urandom_range((last - first) / 2);
      return 1;
   endfunction

   initial begin
      int col;
      int row;
      int depth;
      bit shaped;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_pace(PACE_STEADY);

      // A 64 x 48 box at the default optics: corners, edges, odd offsets, depth limits.
      load_config(320, 240, 64, 48, 5149, 3796, 27239, 27254);
      send_pixel(288, 216, 101, 0, 0, 0);
      send_pixel(350, 262, 4999, 255, 255, 255);
      send_pixel(351, 216, 1000, $urandom_range(255), $urandom_range(255), 7);
      send_pixel(288, 217, 1000, $urandom_range(255), 9, $urandom_range(255));
      send_pixel(287, 216, 1000, 1, $urandom_range(255), $urandom_range(255));
      send_pixel(352, 216, 1000, 2, 3, 4);
      send_pixel(288, 215, 1000, 5, 6, 7);
      send_pixel(288, 264, 1000, 8, 9, 10);
      send_pixel(300, 230, 100, 11, 12, 13);
      send_pixel(300, 230, 5000, 14, 15, 16);
      send_pixel(300, 230, 0, 17, 18, 19);
      send_pixel(300, 230, 65535, 20, 21, 22);
      send_pixel(320, 240, 1500, 8'hAA, 8'h55, 8'h0F);
      wait_idle();

      // A box reaching past the image edges, and reciprocal focals above range, so
      // that both saturation limits are hit.
      load_config(1023, 0, 1023, 1023, 0, 16383, 262143, 262143);
      send_pixel(638, 1, 4999, 255, 0, 255);
      send_pixel(512, 479, 101, 0, 255, 0);
      send_pixel(640, 1, 1000, 30, 31, 32);
      send_pixel(1023, 1, 1000, 33, 34, 35);
      send_pixel(600, 480, 1000, 36, 37, 38);
      send_pixel(600, 1023, 1000, 39, 40, 41);
      wait_idle();

      // Sizes of one and zero leave the box empty.
      load_config(320, 240, 1, 0, 5149, 3796, 27239, 27254);
      send_pixel(320, 240, 1000, 42, 43, 44);
      send_pixel(319, 240, 1000, 45, 46, 47);
      wait_idle();

      // Rounding ties in both directions on X, and a zero reciprocal focal on Y.
      load_config(320, 240, 1023, 1023, 1615, 1617, 65536, 0);
      send_pixel(101, 1, 128, 48, 49, 50);
      send_pixel(99, 479, 128, 51, 52, 53);
      send_pixel(639, 3, 4999, 54, 55, 56);
      wait_idle();

      // Random phases: mostly pixels aimed into the box, the rest anywhere.
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         set_pace(pace_type'(k % 4));
         case (k)
            0: load_config(0, 0, 1023, 1023, 0, 0, 4194, 4194);
            1: load_config(1023, $urandom_range(IMAGE_HEIGHT - 1), 1023,
                           $urandom_range(480, 2), 16383, 16383, 167772, 167772);
            default: load_config($urandom_range(IMAGE_WIDTH - 1),
                                 $urandom_range(IMAGE_HEIGHT - 1),
                                 $urandom_range(400, 2), $urandom_range(400, 2),
                                 $urandom_range(16383), $urandom_range(16383),
                                 $urandom_range(167772, 4194), $urandom_range(167772, 4194));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            shaped = $urandom_range(99) < 80;
            if (shaped) shaped = pick_in_box(box_cx, box_w, IMAGE_WIDTH, col);
            if (shaped) shaped = pick_in_box(box_cy, box_h, IMAGE_HEIGHT, row);
            if (shaped) begin
               depth = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                                : $urandom_range(4999, 101);
            end else begin
               col = $urandom_range(1023);
               row = $urandom_range(1023);
               depth = $urandom_range(65535);
            end
            send_pixel(col, row, depth, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
         end
         wait_idle();
      end

      if (fail_count == 0 && points_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
